// ----- design/tvg_pkg.sv -----
// tvg_pkg: shared types, register codes, constants and lookup functions
// for the three-voice tone/noise/envelope generator
// no dependencies
package tvg_pkg;

   typedef struct packed {
      logic       mode;
      logic [3:0] register_index;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [4:0] level_a;
      logic [4:0] level_b;
      logic [4:0] level_c;
   } rsp_type;

   typedef struct packed {
      logic [2:0][11:0] tone_period;
      logic [4:0]       noise_period;
      logic [5:0]       mixer_disable;
      logic [2:0][4:0]  volume_setting;
      logic [15:0]      envelope_period;
      logic [3:0]       envelope_shape;
   } ctrl_type;

   typedef struct packed {
      logic [2:0] tone_level;
      logic       noise_level;
      logic [4:0] env_level;
   } gen_type;

   typedef enum logic [1:0] {
      BK_FALL = 2'd0,
      BK_RISE = 2'd1,
      BK_LOW  = 2'd2,
      BK_HIGH = 2'd3
   } blk_type;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   localparam logic [3:0] REG_TONE_A_LO = 4'd0;
   localparam logic [3:0] REG_TONE_A_HI = 4'd1;
   localparam logic [3:0] REG_TONE_B_LO = 4'd2;
   localparam logic [3:0] REG_TONE_B_HI = 4'd3;
   localparam logic [3:0] REG_TONE_C_LO = 4'd4;
   localparam logic [3:0] REG_TONE_C_HI = 4'd5;
   localparam logic [3:0] REG_NOISE     = 4'd6;
   localparam logic [3:0] REG_MIXER     = 4'd7;
   localparam logic [3:0] REG_VOL_A     = 4'd8;
   localparam logic [3:0] REG_VOL_B     = 4'd9;
   localparam logic [3:0] REG_VOL_C     = 4'd10;
   localparam logic [3:0] REG_ENV_LO    = 4'd11;
   localparam logic [3:0] REG_ENV_HI    = 4'd12;
   localparam logic [3:0] REG_SHAPE     = 4'd13;

   localparam logic [16:0] LFSR_TAPS     = 17'h12000;
   localparam logic [16:0] LFSR_RESET    = 17'h00001;
   localparam logic [6:0]  ENV_END       = 7'd96;
   localparam logic [6:0]  ENV_LOOP      = 7'd64;
   localparam logic [4:0]  LEVEL_MAX     = 5'h1f;

   function automatic logic [4:0] fixed_level(input logic [3:0] vol);
      logic [4:0] lvl;
      begin
         if (vol == 4'd0) begin
            lvl = 5'd0;
         end else if (vol == 4'd1) begin
            lvl = 5'd1;
         end else begin
            lvl = {vol, 1'b1};
         end
         return lvl;
      end
   endfunction

   function automatic blk_type shape_block(input logic [3:0] shape, input logic [1:0] blk);
      blk_type first;
      blk_type rest;
      blk_type mid;
      begin
         first = shape[2] ? BK_RISE : BK_FALL;
         rest  = BK_LOW;
         mid   = BK_LOW;
         if (shape[3]) begin
            case (shape[1:0])
               2'd0: begin
                  mid  = first;
                  rest = first;
               end
               2'd1: begin
                  mid  = BK_LOW;
                  rest = BK_LOW;
               end
               2'd2: begin
                  mid  = shape[2] ? BK_FALL : BK_RISE;
                  rest = first;
               end
               default: begin
                  mid  = shape[2] ? BK_LOW : BK_HIGH;
                  rest = mid;
               end
            endcase
            if (shape == 4'd15) begin
               mid  = BK_LOW;
               rest = BK_LOW;
            end
            if (shape == 4'd13) begin
               mid  = BK_HIGH;
               rest = BK_HIGH;
            end
         end
         case (blk)
            2'd0:    return first;
            2'd1:    return mid;
            default: return rest;
         endcase
      end
   endfunction

   function automatic logic [4:0] env_level(input logic [3:0] shape, input logic [6:0] pos);
      logic [6:0] p;
      logic [4:0] step;
      logic [4:0] lvl;
      begin
         p    = (pos >= ENV_END) ? ENV_END - 7'd1 : pos;
         step = p[4:0];
         case (shape_block(shape, p[6:5]))
            BK_FALL: lvl = LEVEL_MAX - step;
            BK_RISE: lvl = step;
            BK_LOW:  lvl = 5'd0;
            default: lvl = LEVEL_MAX;
         endcase
         return lvl;
      end
   endfunction

endpackage

// ----- design/tvg_regs.sv -----
// tvg_regs: control register file written by write words
// depends on tvg_pkg
module tvg_regs
   import tvg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [3:0] wr_index,
   input  logic [7:0] wr_data,
   output ctrl_type   ctrl,
   output logic       env_restart
);

   ctrl_type ctrl_ff;
   ctrl_type ctrl_in;

   always_comb begin
      ctrl_in     = ctrl_ff;
      env_restart = 1'b0;
      if (wr_en) begin
         unique case (wr_index)
            REG_TONE_A_LO: ctrl_in.tone_period[0][7:0]  = wr_data;
            REG_TONE_A_HI: ctrl_in.tone_period[0][11:8] = wr_data[3:0];
            REG_TONE_B_LO: ctrl_in.tone_period[1][7:0]  = wr_data;
            REG_TONE_B_HI: ctrl_in.tone_period[1][11:8] = wr_data[3:0];
            REG_TONE_C_LO: ctrl_in.tone_period[2][7:0]  = wr_data;
            REG_TONE_C_HI: ctrl_in.tone_period[2][11:8] = wr_data[3:0];
            REG_NOISE:     ctrl_in.noise_period         = wr_data[4:0];
            REG_MIXER:     ctrl_in.mixer_disable        = wr_data[5:0];
            REG_VOL_A:     ctrl_in.volume_setting[0]    = wr_data[4:0];
            REG_VOL_B:     ctrl_in.volume_setting[1]    = wr_data[4:0];
            REG_VOL_C:     ctrl_in.volume_setting[2]    = wr_data[4:0];
            REG_ENV_LO:    ctrl_in.envelope_period[7:0]  = wr_data;
            REG_ENV_HI:    ctrl_in.envelope_period[15:8] = wr_data;
            REG_SHAPE: begin
               ctrl_in.envelope_shape = wr_data[3:0];
               env_restart            = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl = ctrl_ff;

endmodule

// ----- design/tvg_core.sv -----
// tvg_core: tone counters, noise divider and shift register, envelope counter
// presents the post-tick generator outputs; depends on tvg_pkg
module tvg_core
   import tvg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     tick,
   input  logic     env_restart,
   input  ctrl_type ctrl,
   output gen_type  gen
);

   logic [2:0][11:0] tone_count_ff, tone_count_in;
   logic [2:0]       tone_level_ff, tone_level_in;
   logic [4:0]       noise_count_ff, noise_count_in;
   logic             half_rate_ff, half_rate_in;
   logic             noise_level_ff, noise_level_in;
   logic [16:0]      noise_shift_ff, noise_shift_in;
   logic [15:0]      env_count_ff, env_count_in;
   logic [6:0]       env_pos_ff, env_pos_in;

   always_comb begin
      tone_count_in  = tone_count_ff;
      tone_level_in  = tone_level_ff;
      noise_count_in = noise_count_ff;
      half_rate_in   = half_rate_ff;
      noise_level_in = noise_level_ff;
      noise_shift_in = noise_shift_ff;
      env_count_in   = env_count_ff;
      env_pos_in     = env_pos_ff;
      if (env_restart) begin
         env_count_in = '0;
         env_pos_in   = '0;
      end else if (tick) begin
         half_rate_in = ~half_rate_ff;
         if (!half_rate_in) begin
            noise_count_in = noise_count_ff + 5'd1;
         end
         if (noise_count_in >= ctrl.noise_period) begin
            noise_count_in = '0;
            noise_level_in = noise_shift_ff[0];
            noise_shift_in = {1'b0, noise_shift_ff[16:1]}
                             ^ (noise_shift_ff[0] ? LFSR_TAPS : '0);
         end
         for (int v = 0; v < 3; v++) begin
            tone_count_in[v] = tone_count_ff[v] + 12'd1;
            if (tone_count_in[v] >= ctrl.tone_period[v]) begin
               tone_count_in[v] = '0;
               tone_level_in[v] = ~tone_level_ff[v];
            end
         end
         env_count_in = env_count_ff + 16'd1;
         if (env_count_in >= ctrl.envelope_period) begin
            env_count_in = '0;
            env_pos_in   = env_pos_ff + 7'd1;
            if (env_pos_in >= ENV_END) begin
               env_pos_in = env_pos_in - ENV_LOOP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_count_ff  <= '0;
         tone_level_ff  <= '0;
         noise_count_ff <= '0;
         half_rate_ff   <= 1'b0;
         noise_level_ff <= 1'b0;
         noise_shift_ff <= LFSR_RESET;
         env_count_ff   <= '0;
         env_pos_ff     <= '0;
      end else begin
         tone_count_ff  <= tone_count_in;
         tone_level_ff  <= tone_level_in;
         noise_count_ff <= noise_count_in;
         half_rate_ff   <= half_rate_in;
         noise_level_ff <= noise_level_in;
         noise_shift_ff <= noise_shift_in;
         env_count_ff   <= env_count_in;
         env_pos_ff     <= env_pos_in;
      end
   end

   assign gen.tone_level  = tone_level_in;
   assign gen.noise_level = noise_level_in;
   assign gen.env_level   = env_level(ctrl.envelope_shape, env_pos_in);

endmodule

// ----- design/tvg_mix.sv -----
// tvg_mix: mixer gating and volume / envelope level selection per voice
// depends on tvg_pkg
module tvg_mix
   import tvg_pkg::*;
(
   input  ctrl_type ctrl,
   input  gen_type  gen,
   output rsp_type  levels
);

   logic [2:0][4:0] lvl;

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         lvl[v] = 5'd0;
         if ((gen.tone_level[v] | ctrl.mixer_disable[v])
             && (gen.noise_level | ctrl.mixer_disable[v + 3])) begin
            lvl[v] = ctrl.volume_setting[v][4] ? gen.env_level
                                               : fixed_level(ctrl.volume_setting[v][3:0]);
         end
      end
   end

   assign levels.level_a = lvl[0];
   assign levels.level_b = lvl[1];
   assign levels.level_c = lvl[2];

endmodule

// ----- design/three_voice_tone_noise_envelope_gen.sv -----
// three_voice_tone_noise_envelope_gen: top level, input register, result register
// a tick word is held in the input register; its levels are captured in the result register
// throughput: one word per cycle unless a tick word is stalled; a write word leaves no result
// the result register stalls the input register only while rsp_ready is low
// reset clears all control registers and counters; the noise shift register starts at one
// depends on tvg_pkg, tvg_regs, tvg_core, tvg_mix
module three_voice_tone_noise_envelope_gen
   import tvg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   req_type  req_ff;
   logic     req_valid_ff;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;
   logic     rsp_free;
   logic     advance;
   logic     do_tick;
   logic     do_write;
   logic     env_restart;
   ctrl_type ctrl;
   gen_type  gen;
   rsp_type  levels;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && ((req_ff.mode == MODE_WRITE) || rsp_free);
   assign req_ready = !req_valid_ff || advance;
   assign do_tick   = advance && (req_ff.mode == MODE_TICK);
   assign do_write  = advance && (req_ff.mode == MODE_WRITE);

   tvg_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (do_write),
      .wr_index    (req_ff.register_index),
      .wr_data     (req_ff.write_data),
      .ctrl        (ctrl),
      .env_restart (env_restart)
   );

   tvg_core u_core (
      .clock       (clock),
      .reset       (reset),
      .tick        (do_tick),
      .env_restart (env_restart),
      .ctrl        (ctrl),
      .gen         (gen)
   );

   tvg_mix u_mix (
      .ctrl   (ctrl),
      .gen    (gen),
      .levels (levels)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (do_tick) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_word;
      end
      if (do_tick) begin
         rsp_ff <= levels;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- test/tvg_level_checker.sv -----
// tvg_level_checker: watches both channels of the three-voice generator, keeps its own
// copy of the generator state, predicts the three voice levels of every tick word and
// compares them in order with the result words; depends on tvg_pkg
module tvg_level_checker
   import tvg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_word,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_word,
   output int      fail_count,
   output int      pending,
   output int      checked
);

   logic [11:0] tone_period [3];
   logic [11:0] tone_count [3];
   logic        tone_phase [3];
   logic [4:0]  volume [3];
   logic [4:0]  noise_period;
   logic [4:0]  noise_count;
   logic        half_tick;
   logic        noise_bit;
   logic [16:0] lfsr;
   logic [5:0]  mixer_off;
   logic [15:0] env_period;
   logic [15:0] env_count;
   logic [3:0]  env_shape;
   logic [6:0]  env_pos;
   logic [6:0]  env_p;
   logic [4:0]  env_lvl;
   blk_type     seg [3];
   logic [4:0]  lv [3];
   rsp_type     due;
   rsp_type     due_levels [$];
   int          v;
   int          sel;

   logic [4:0] vol_curve [16] = '{5'd0, 5'd1, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd15,
                                  5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd29, 5'd31};

   task automatic check_field(input string name, input logic [4:0] want, input logic [4:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (v = 0; v < 3; v++) begin
            tone_period[v] = '0;
            tone_count[v]  = '0;
            tone_phase[v]  = 1'b0;
            volume[v]      = '0;
         end
         noise_period = '0;
         noise_count  = '0;
         half_tick    = 1'b0;
         noise_bit    = 1'b0;
         lfsr         = LFSR_RESET;
         mixer_off    = '0;
         env_period   = '0;
         env_count    = '0;
         env_shape    = '0;
         env_pos      = '0;
         due_levels.delete();
         fail_count   = 0;
         checked      = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_levels.size() == 0) begin
               $error("level word %h arrived with nothing expected", rsp_word);
               fail_count++;
            end else begin
               due = due_levels.pop_front();
               check_field("level_a", due.level_a, rsp_word.level_a);
               check_field("level_b", due.level_b, rsp_word.level_b);
               check_field("level_c", due.level_c, rsp_word.level_c);
               checked++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_word.mode == MODE_WRITE) begin
               sel = req_word.register_index[2:1];
               case (req_word.register_index)
                  REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO: begin
                     tone_period[sel][7:0] = req_word.write_data;
                  end
                  REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: begin
                     tone_period[sel][11:8] = req_word.write_data[3:0];
                  end
                  REG_NOISE: noise_period = req_word.write_data[4:0];
                  REG_MIXER: mixer_off = req_word.write_data[5:0];
                  REG_VOL_A: volume[0] = req_word.write_data[4:0];
                  REG_VOL_B: volume[1] = req_word.write_data[4:0];
                  REG_VOL_C: volume[2] = req_word.write_data[4:0];
                  REG_ENV_LO: env_period[7:0] = req_word.write_data;
                  REG_ENV_HI: env_period[15:8] = req_word.write_data;
                  REG_SHAPE: begin
                     env_shape = req_word.write_data[3:0];
                     env_pos   = '0;
                     env_count = '0;
                  end
                  default: ;
               endcase
            end else begin
               half_tick = ~half_tick;
               if (!half_tick) noise_count = noise_count + 5'd1;
               if (noise_count >= noise_period) begin
                  noise_count = '0;
                  noise_bit   = lfsr[0];
                  lfsr        = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 17'd0);
               end
               for (v = 0; v < 3; v++) begin
                  tone_count[v] = tone_count[v] + 12'd1;
                  if (tone_count[v] >= tone_period[v]) begin
                     tone_count[v] = '0;
                     tone_phase[v] = ~tone_phase[v];
                  end
               end
               env_count = env_count + 16'd1;
               if (env_count >= env_period) begin
                  env_count = '0;
                  env_pos   = env_pos + 7'd1;
                  if (env_pos >= ENV_END) env_pos = env_pos - ENV_LOOP;
               end
               case (env_shape)
                  4'd8:  begin seg[0] = BK_FALL; seg[1] = BK_FALL; seg[2] = BK_FALL; end
                  4'd10: begin seg[0] = BK_FALL; seg[1] = BK_RISE; seg[2] = BK_FALL; end
                  4'd11: begin seg[0] = BK_FALL; seg[1] = BK_HIGH; seg[2] = BK_HIGH; end
                  4'd12: begin seg[0] = BK_RISE; seg[1] = BK_RISE; seg[2] = BK_RISE; end
                  4'd13: begin seg[0] = BK_RISE; seg[1] = BK_HIGH; seg[2] = BK_HIGH; end
                  4'd14: begin seg[0] = BK_RISE; seg[1] = BK_FALL; seg[2] = BK_RISE; end
                  4'd4, 4'd5, 4'd6, 4'd7, 4'd15: begin
                     seg[0] = BK_RISE; seg[1] = BK_LOW; seg[2] = BK_LOW;
                  end
                  default: begin seg[0] = BK_FALL; seg[1] = BK_LOW; seg[2] = BK_LOW; end
               endcase
               env_p = (env_pos >= ENV_END) ? ENV_END - 7'd1 : env_pos;
               case (seg[env_p[6:5]])
                  BK_FALL: env_lvl = LEVEL_MAX - env_p[4:0];
                  BK_RISE: env_lvl = env_p[4:0];
                  BK_LOW:  env_lvl = 5'd0;
                  default: env_lvl = LEVEL_MAX;
               endcase
               for (v = 0; v < 3; v++) begin
                  lv[v] = 5'd0;
                  if ((tone_phase[v] | mixer_off[v]) && (noise_bit | mixer_off[v + 3])) begin
                     lv[v] = volume[v][4] ? env_lvl : vol_curve[volume[v][3:0]];
                  end
               end
               due.level_a = lv[0];
               due.level_b = lv[1];
               due.level_c = lv[2];
               due_levels.push_back(due);
            end
         end
      end
      pending = due_levels.size();
   end

endmodule

// ----- test/tb_three_voice_tone_noise_envelope_gen.sv -----
// tb_three_voice_tone_noise_envelope_gen: drives register writes and ticks into the
// generator with random idling and stalls, verdict from tvg_level_checker
// depends on tvg_pkg, three_voice_tone_noise_envelope_gen, tvg_level_checker
module tb_three_voice_tone_noise_envelope_gen;
   import tvg_pkg::*;

   localparam logic [3:0] REG_SPARE_LO = 4'd14;
   localparam logic [3:0] REG_SPARE_HI = 4'd15;
   localparam int         RANDOM_WORDS = 1150;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_word;
   int      fail_count;
   int      pending;
   int      checked;

   bit      sender_steady = 1'b0;
   bit      rx_steady = 1'b0;
   bit      hold_request = 1'b0;
   int      words_sent = 0;
   int      scene = 0;
   int      holds = 0;
   int      drains = 0;

   always #6 clock = ~clock;

   three_voice_tone_noise_envelope_gen uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   tvg_level_checker level_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] reg_data(input logic [3:0] idx);
      logic [7:0] r;
      r = 8'($urandom);
      case (idx)
         REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO: begin
            if ($urandom_range(0, 3) != 0) r = 8'($urandom_range(0, 12));
         end
         REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: begin
            if ($urandom_range(0, 3) != 0) r[3:0] = 4'h0;
         end
         REG_ENV_LO: if ($urandom_range(0, 3) != 0) r = 8'($urandom_range(0, 3));
         REG_ENV_HI: if ($urandom_range(0, 4) != 0) r = 8'h00;
         default: ;
      endcase
      return r;
   endfunction

   // called at a falling edge, returns at a falling edge with valid possibly still high
   task automatic send_word(input req_type w);
      int gap;
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (w.mode == MODE_TICK || w.register_index <= REG_SHAPE) words_sent++;
      @(negedge clock);
      gap = sender_steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_write(input logic [3:0] idx, input logic [7:0] data);
      req_type w;
      w.mode           = MODE_WRITE;
      w.register_index = idx;
      w.write_data     = data;
      send_word(w);
   endtask

   task automatic send_ticks(input int n);
      req_type w;
      repeat (n) begin
         w.mode           = MODE_TICK;
         w.register_index = 4'($urandom);
         w.write_data     = 8'($urandom);
         send_word(w);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      drains++;
   endtask

   initial begin
      int lull;
      int hold_left;
      lull      = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 160;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (lull > 0) begin
            lull--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0) lull = idle_len();
         end
      end
   end

   initial begin
      #4800000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int start;
      int n;
      req_type w;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, ignored bits, spare registers, shape restart
      send_ticks(1);
      send_write(REG_VOL_A, 8'hff);
      send_write(REG_VOL_B, 8'h0f);
      send_write(REG_VOL_C, 8'he1);
      send_write(REG_TONE_A_LO, 8'hff);
      send_write(REG_TONE_A_HI, 8'hff);
      send_write(REG_TONE_C_LO, 8'h01);
      send_write(REG_NOISE, 8'hff);
      send_write(REG_MIXER, 8'hff);
      send_write(REG_SHAPE, 8'hfe);
      send_write(REG_SPARE_LO, 8'hff);
      send_write(REG_SPARE_HI, 8'h5a);
      send_ticks(3);
      send_write(REG_SHAPE, 8'h0e);
      send_write(REG_MIXER, 8'hc0);
      send_write(REG_ENV_HI, 8'hff);
      send_write(REG_ENV_LO, 8'hff);
      send_ticks(2);
      send_write(REG_TONE_A_HI, 8'h00);
      send_write(REG_TONE_A_LO, 8'h01);
      send_ticks(2);
      send_write(REG_ENV_HI, 8'h00);
      send_write(REG_ENV_LO, 8'h00);
      send_ticks(2);
      wait_idle();

      // random scenes: a short register program followed by a run of ticks, or a long output hold under steady ticks
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         scene++;
         sender_steady = ($urandom_range(0, 5) == 0);
         rx_steady     = ($urandom_range(0, 5) == 0);
         if (scene == 4 || scene == 31) begin
            hold_request  = 1'b1;
            sender_steady = 1'b1;
            holds++;
            send_ticks(80);
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               if ($urandom_range(0, 99) < 8) begin
                  w = req_type'($urandom);
                  send_word(w);
               end else begin
                  w.register_index = 4'($urandom_range(0, 13));
                  send_write(w.register_index, reg_data(w.register_index));
               end
            end
            send_ticks($urandom_range(8, 60));
         end
         if (scene % 9 == 0) wait_idle();
      end
      sender_steady = 1'b0;
      rx_steady     = 1'b0;
      wait_idle();

      $display("covered %0d words in %0d random scenes, %0d level words compared",
               words_sent, scene, checked);
      $display("with %0d long output stalls under input pressure and %0d full drains",
               holds, drains);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
